[rtl/core/line_sensor_position_estimator_unit_defines.svh]
// Assertion macros shared by the line sensor position estimator RTL.
`ifndef LINE_SENSOR_POSITION_ESTIMATOR_UNIT_DEFINES_SVH
`define LINE_SENSOR_POSITION_ESTIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LSPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define LSPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lspe_pkg.sv]
// Shared types, field widths and constants of the line sensor position estimator.
package lspe_pkg;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 4;
  localparam int RAW_W  = 12;
  localparam int THR_W  = 12;
  localparam int POS_W  = 14;
  localparam int CNT_W  = 5;
  localparam int MASK_W = 16;

  localparam logic [CMD_W-1:0] CMD_CAL     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET  = 12'd2048;
  localparam logic [POS_W-1:0] POS_CENTER = 14'd7500;
  localparam logic [RAW_W-1:0] RAW_TOP    = 12'd4095;
  localparam int               POS_SCALE  = 1000;

  // Calibration write request into the min/max store.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [RAW_W-1:0] raw;
  } cal_wr_t;

  // Position weight of a sensor: index times the position scale.
  function automatic logic [POS_W-1:0] pos_weight(input logic [IDX_W-1:0] idx);
    return POS_W'(int'(idx) * POS_SCALE);
  endfunction

endpackage

[rtl/core/lspe_cal.sv]
// Per-sensor calibration window store: running minimum and maximum reading.
module lspe_cal #(
  parameter int NUM_SENSORS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lspe_pkg::cal_wr_t        wr,
  input  logic [lspe_pkg::IDX_W-1:0] rd_idx,
  output logic [lspe_pkg::RAW_W-1:0] rd_lo,
  output logic [lspe_pkg::RAW_W-1:0] rd_hi
);
  import lspe_pkg::*;

  localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  logic [RAW_W-1:0] lo_store [NUM_SENSORS];
  logic [RAW_W-1:0] hi_store [NUM_SENSORS];
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  assign wr_addr = AW'(wr.idx);
  assign rd_addr = AW'(rd_idx);

  // Widen the window on every calibration request.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        lo_store[i] <= RAW_TOP;
        hi_store[i] <= '0;
      end
    end else if (wr.en) begin
      if (wr.raw < lo_store[wr_addr]) begin
        lo_store[wr_addr] <= wr.raw;
      end
      if (wr.raw > hi_store[wr_addr]) begin
        hi_store[wr_addr] <= wr.raw;
      end
    end
  end

  assign rd_lo = lo_store[rd_addr];
  assign rd_hi = hi_store[rd_addr];

endmodule

[rtl/core/lspe_div.sv]
// Shared restoring divider: one quotient bit per cycle, quotient known to fit QW bits.
module lspe_div #(
  parameter int DDW = 50,
  parameter int DVW = 36,
  parameter int QW  = 14
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DDW-1:0] dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [QW-1:0]  quotient
);
  import lspe_pkg::*;

  localparam int CW    = DVW + QW;
  localparam int CNT_B = $clog2(QW + 1);

  logic [CW-1:0]    rem;
  logic [CW-1:0]    dsh;
  logic [CNT_B-1:0] cnt;
  logic             busy;
  logic             ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_B'(QW);
      end else if (busy) begin
        cnt <= cnt - CNT_B'(1);
        if (cnt == CNT_B'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: trial subtract of the shifted divisor, one bit per step.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= CW'(dividend);
      dsh      <= CW'(divisor) << (QW - 1);
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= {quotient[QW-2:0], ge};
    end
  end

endmodule

[rtl/core/line_sensor_position_estimator_unit.sv]
// Top level of the line sensor position estimator: sequencer, accumulators, result register.
//
// Input channel (in_valid / in_stall) carries one request: cmd, sensor_index,
// raw_value and last. Calibration (cmd 0) widens that sensor's min/max window
// and finish (cmd 1) switches on rescaling; neither stalls the input. A measurement
// (cmd 2) rescales the reading, through the one-bit-per-cycle shared divider when
// it lies strictly inside a calibrated window, compares it with threshold and
// accumulates it when at or above. A measurement with last set then divides the
// weighted sum by the value sum on the same divider when the value sum is not
// zero, and loads one result into the output register.
// in_stall is high during reset and while a request is being worked on.
// Output channel (out_valid / out_stall): the result holds until taken. While
// it waits, further requests are still taken; a sweep end waits for it.
// threshold is to be written through cfg_wr_en / cfg_wr_data only while idle; the block
// does not enforce this. Synchronous reset restores the calibration windows, threshold
// 2048, the centre position 7500, clears the sums and drops any pending result.
// Sums are exact for sweeps of fewer than 2**24 accumulated samples.
`include "line_sensor_position_estimator_unit_defines.svh"

module line_sensor_position_estimator_unit #(
  parameter int NUM_SENSORS = 16,
  parameter int ADC_MAX     = 4095
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lspe_pkg::THR_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lspe_pkg::CMD_W-1:0]  cmd,
  input  logic [lspe_pkg::IDX_W-1:0]  sensor_index,
  input  logic [lspe_pkg::RAW_W-1:0]  raw_value,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lspe_pkg::POS_W-1:0]  line_position,
  output logic                        on_line,
  output logic [lspe_pkg::CNT_W-1:0]  active_count,
  output logic [lspe_pkg::MASK_W-1:0] active_mask
);
  import lspe_pkg::*;

  localparam int ADC_W = $clog2(ADC_MAX + 1);
  localparam int VAL_W = (ADC_W > RAW_W) ? ADC_W : RAW_W;
  localparam int QW    = (ADC_W > POS_W) ? ADC_W : POS_W;
  localparam int VS_W  = VAL_W + 24;
  localparam int WS_W  = VS_W + POS_W;
  localparam int NUM_W = RAW_W + ADC_W;
  localparam int PRD_W = VAL_W + POS_W;

  localparam logic [ADC_W-1:0] ADC_MAX_C = ADC_W'(ADC_MAX);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCALE = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_RWAIT = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_END   = 4'd6;
  localparam logic [3:0] S_PWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [THR_W-1:0] threshold;
  logic             is_cal;

  logic [IDX_W-1:0] idx_q;
  logic [RAW_W-1:0] raw_q;
  logic             last_q;
  logic [VAL_W-1:0] v_q;
  logic [NUM_W-1:0] num_q;
  logic [RAW_W-1:0] den_q;
  logic [PRD_W-1:0] prod_q;

  logic [VS_W-1:0]   value_sum;
  logic [WS_W-1:0]   weighted_sum;
  logic [CNT_W-1:0]  hit_count;
  logic [MASK_W-1:0] hit_mask;
  logic [POS_W-1:0]  held_position;

  logic              in_acc;
  logic              in_idx_ok;
  logic              idx_ok;
  logic              out_take;
  logic              load;
  cal_wr_t           cal_wr;
  logic [RAW_W-1:0]  lo;
  logic [RAW_W-1:0]  hi;
  logic [RAW_W-1:0]  diff;

  logic              div_start;
  logic              div_done;
  logic [WS_W-1:0]   div_dividend;
  logic [VS_W-1:0]   div_divisor;
  logic [QW-1:0]     div_q;

  assign in_stall  = rst || (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_idx_ok = int'(sensor_index) < NUM_SENSORS;
  assign idx_ok    = int'(idx_q) < NUM_SENSORS;
  assign out_take  = out_valid && !out_stall;
  assign load      = (state == S_OUT) && (!out_valid || !out_stall);
  assign diff      = raw_q - lo;

  assign cal_wr.en  = in_acc && (cmd == CMD_CAL) && in_idx_ok;
  assign cal_wr.idx = sensor_index;
  assign cal_wr.raw = raw_value;

  lspe_cal #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_cal (
    .clk    (clk),
    .rst    (rst),
    .wr     (cal_wr),
    .rd_idx (idx_q),
    .rd_lo  (lo),
    .rd_hi  (hi)
  );

  // One divider serves the rescale and the sweep position.
  assign div_start    = (state == S_MUL) ||
                        ((state == S_END) && last_q && (value_sum != '0));
  assign div_dividend = (state == S_END) ? weighted_sum : WS_W'(num_q);
  assign div_divisor  = (state == S_END) ? value_sum : VS_W'(den_q);

  lspe_div #(
    .DDW (WS_W),
    .DVW (VS_W),
    .QW  (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && (cmd == CMD_MEASURE)) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        if (!idx_ok) begin
          state_next = S_END;
        end else if (is_cal && (hi > lo) && (raw_q > lo) && (raw_q < hi)) begin
          state_next = S_MUL;
        end else begin
          state_next = S_ACC;
        end
      end
      S_MUL:   state_next = S_RWAIT;
      S_RWAIT: begin
        if (div_done) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        if (v_q >= VAL_W'(threshold)) begin
          state_next = S_ADD;
        end else begin
          state_next = S_END;
        end
      end
      S_ADD:   state_next = S_END;
      S_END: begin
        if (!last_q) begin
          state_next = S_IDLE;
        end else if (value_sum != '0) begin
          state_next = S_PWAIT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_PWAIT: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      threshold     <= THR_RESET;
      is_cal        <= 1'b0;
      value_sum     <= '0;
      weighted_sum  <= '0;
      hit_count     <= '0;
      hit_mask      <= '0;
      held_position <= POS_CENTER;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (in_acc && (cmd == CMD_FINISH)) begin
        is_cal <= 1'b1;
      end
      if ((state == S_ACC) && (v_q >= VAL_W'(threshold))) begin
        value_sum <= value_sum + VS_W'(v_q);
        hit_mask  <= hit_mask | (MASK_W'(1) << idx_q);
        if (hit_count != '1) begin
          hit_count <= hit_count + CNT_W'(1);
        end
      end
      if (state == S_ADD) begin
        weighted_sum <= weighted_sum + WS_W'(prod_q);
      end
      if ((state == S_PWAIT) && div_done) begin
        held_position <= div_q[POS_W-1:0];
      end
      if (load) begin
        out_valid    <= 1'b1;
        value_sum    <= '0;
        weighted_sum <= '0;
        hit_count    <= '0;
        hit_mask     <= '0;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_q  <= sensor_index;
      raw_q  <= raw_value;
      last_q <= last;
    end
    if (state == S_SCALE) begin
      if (!is_cal || (hi <= lo)) begin
        v_q <= VAL_W'(raw_q);
      end else if (raw_q <= lo) begin
        v_q <= '0;
      end else begin
        // Reading at or above max saturates to full scale.
        v_q <= VAL_W'(ADC_MAX_C);
      end
      num_q <= NUM_W'(diff) * NUM_W'(ADC_MAX_C);
      den_q <= hi - lo;
    end
    if ((state == S_RWAIT) && div_done) begin
      v_q <= div_q[VAL_W-1:0];
    end
    if (state == S_ACC) begin
      prod_q <= PRD_W'(v_q) * PRD_W'(pos_weight(idx_q));
    end
    if (load) begin
      line_position <= held_position;
      on_line       <= (value_sum != '0);
      active_count  <= hit_count;
      active_mask   <= hit_mask;
    end
  end

  `LSPE_ASSERT_IMP(a_res_from_out, $rose(out_valid), $past(state) == S_OUT, "result without sweep end")
  `LSPE_ASSERT_NXT(a_sums_cleared, load, (value_sum == '0) && (hit_mask == '0), "sums not cleared")
  `LSPE_ASSERT_IMP(a_count_mask, 1'b1, (hit_count == '0) == (hit_mask == '0), "count and mask disagree")
  `LSPE_ASSERT_IMP(a_done_in_wait, div_done, (state == S_RWAIT) || (state == S_PWAIT), "stray divide")
  `LSPE_ASSERT_IMP(a_rescale_range, (state == S_RWAIT) && div_done, div_q < QW'(ADC_MAX), "rescale overflow")

endmodule
